>>> design/mfrs_pkg.sv
// Package for the media fragment run summarizer.
// Holds the field widths, the sample, queue entry and summary types, and the queue depth default.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package mfrs_pkg;

    localparam int SIZE_BITS  = 32;
    localparam int DUR_BITS   = 32;
    localparam int TIME_BITS  = 48;
    localparam int COUNT_BITS = 16;

    // Default depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    typedef logic [SIZE_BITS-1:0]  size_t;
    typedef logic [DUR_BITS-1:0]   dur_t;
    typedef logic [TIME_BITS-1:0]  time_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    localparam count_t COUNT_MAX = '1;
    localparam time_t  TIME_ALL_ONES = '1;

    typedef struct packed {
        size_t sample_size;
        dur_t  sample_duration;
        logic  key_frame;
        time_t present_time;
        time_t decode_stamp;
        logic  ends_fragment;
    } mfrs_sample_t;

    // A classified sample as it waits in the queue: the two stamps are
    // already compared, so only the presentation time travels on.
    typedef struct packed {
        size_t sample_size;
        dur_t  sample_duration;
        logic  key_frame;
        time_t present_time;
        logic  has_offset;
        logic  ends_fragment;
    } mfrs_entry_t;

    typedef struct packed {
        count_t count_of_samples;
        time_t  total_duration;
        time_t  base_decode_time;
        time_t  earliest_present;
        logic   sap_found;
        time_t  sap_delta;
        logic   opens_on_key;
        dur_t   common_duration;
        logic   sizes_uniform;
        size_t  common_size;
        logic   flags_uniform;
        logic   offsets_present;
    } mfrs_summary_t;

endpackage

`default_nettype wire

>>> design/mfrs_if.sv
// Handshake interfaces of the media fragment run summarizer.
// One interface carries samples, the other fragment summaries; both use mfrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mfrs_sample_if;
    import mfrs_pkg::*;

    logic         valid;
    logic         ready;
    mfrs_sample_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mfrs_summary_if;
    import mfrs_pkg::*;

    logic          valid;
    logic          ready;
    mfrs_summary_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> design/mfrs_front.sv
// Front of the summarizer: accepts samples, compares the two stamps and
// queues the classified samples for the back. Depends on mfrs_pkg and mfrs_if.
`timescale 1ns / 1ps
`default_nettype none

module mfrs_front #(
    parameter int QUEUE_DEPTH = mfrs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire                  clk,
    input  wire                  rst_n,
    mfrs_sample_if.sink          samples,
    output logic                 head_valid,
    output mfrs_pkg::mfrs_entry_t head_entry,
    input  wire                  head_pop
);
    import mfrs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    mfrs_entry_t        queue_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    mfrs_entry_t        classified;
    logic               push;
    logic               pop;

    always_comb
    begin
        classified.sample_size     = samples.payload.sample_size;
        classified.sample_duration = samples.payload.sample_duration;
        classified.key_frame       = samples.payload.key_frame;
        classified.present_time    = samples.payload.present_time;
        classified.has_offset      = samples.payload.present_time
                                     != samples.payload.decode_stamp;
        classified.ends_fragment   = samples.payload.ends_fragment;
    end

    assign samples.ready = (fill_reg != FULL_CNT);
    assign push          = samples.valid && samples.ready;
    assign head_valid    = (fill_reg != '0);
    assign pop           = head_pop && head_valid;
    assign head_entry    = queue_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= classified;
        end
    end

endmodule

`default_nettype wire

>>> design/mfrs_back.sv
// Back of the summarizer: folds queued samples into the fragment statistics
// and holds the finished summary in an output register. Depends on mfrs_pkg and mfrs_if.
`timescale 1ns / 1ps
`default_nettype none

module mfrs_back (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   head_valid,
    input  mfrs_pkg::mfrs_entry_t head_entry,
    output logic                  head_pop,
    mfrs_summary_if.source        summaries
);
    import mfrs_pkg::*;

    time_t  base_reg;
    time_t  sum_reg, sum_next;
    count_t count_reg, count_next;
    time_t  min_reg, min_next;
    time_t  sap_time_reg, sap_time_next;
    logic   sap_seen_reg, sap_seen_next;
    dur_t   first_dur_reg, first_dur_next;
    logic   dur_same_reg, dur_same_next;
    size_t  first_size_reg, first_size_next;
    logic   size_same_reg, size_same_next;
    logic   first_key_reg, first_key_next;
    logic   key_same_reg, key_same_next;
    logic   offset_reg, offset_next;

    logic          out_valid_reg;
    mfrs_summary_t out_reg;
    mfrs_summary_t summary;

    logic  first_sample;
    logic  below_min;
    time_t delta_vs_old;
    time_t delta_vs_new;
    logic  closing;

    // A closing sample needs a free output slot; other samples always drain.
    assign head_pop = head_valid
                      && (!head_entry.ends_fragment || !out_valid_reg || summaries.ready);
    assign closing  = head_pop && head_entry.ends_fragment;

    always_comb
    begin
        first_sample = (count_reg == '0);

        first_dur_next  = first_sample ? head_entry.sample_duration : first_dur_reg;
        first_size_next = first_sample ? head_entry.sample_size : first_size_reg;
        first_key_next  = first_sample ? head_entry.key_frame : first_key_reg;

        dur_same_next  = dur_same_reg
                         && (first_sample || head_entry.sample_duration == first_dur_reg);
        size_same_next = size_same_reg
                         && (first_sample || head_entry.sample_size == first_size_reg);
        key_same_next  = key_same_reg
                         && (first_sample || head_entry.key_frame == first_key_reg);

        count_next = (count_reg != COUNT_MAX) ? count_reg + 1'b1 : count_reg;
        sum_next   = sum_reg + TIME_BITS'(head_entry.sample_duration);

        below_min = head_entry.present_time < min_reg;
        min_next  = below_min ? head_entry.present_time : min_reg;

        sap_seen_next = sap_seen_reg || head_entry.key_frame;
        sap_time_next = (head_entry.key_frame && !sap_seen_reg)
                        ? head_entry.present_time : sap_time_reg;
        offset_next   = offset_reg || head_entry.has_offset;

        // Both differences are formed in parallel with the minimum compare.
        delta_vs_old = sap_time_next - min_reg;
        delta_vs_new = sap_time_next - head_entry.present_time;

        summary.count_of_samples = count_next;
        summary.total_duration   = sum_next;
        summary.base_decode_time = base_reg;
        summary.earliest_present = min_next;
        summary.sap_found        = sap_seen_next;
        summary.sap_delta        = !sap_seen_next ? '0
                                   : (below_min ? delta_vs_new : delta_vs_old);
        summary.opens_on_key     = first_key_next;
        summary.common_duration  = dur_same_next ? first_dur_next : '0;
        summary.sizes_uniform    = size_same_next;
        summary.common_size      = first_size_next;
        summary.flags_uniform    = key_same_next;
        summary.offsets_present  = offset_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg       <= '0;
            sum_reg        <= '0;
            count_reg      <= '0;
            min_reg        <= TIME_ALL_ONES;
            sap_time_reg   <= '0;
            sap_seen_reg   <= 1'b0;
            first_dur_reg  <= '0;
            dur_same_reg   <= 1'b1;
            first_size_reg <= '0;
            size_same_reg  <= 1'b1;
            first_key_reg  <= 1'b0;
            key_same_reg   <= 1'b1;
            offset_reg     <= 1'b0;
        end
        else if (closing)
        begin
            base_reg       <= base_reg + sum_reg + TIME_BITS'(head_entry.sample_duration);
            sum_reg        <= '0;
            count_reg      <= '0;
            min_reg        <= TIME_ALL_ONES;
            sap_time_reg   <= '0;
            sap_seen_reg   <= 1'b0;
            first_dur_reg  <= '0;
            dur_same_reg   <= 1'b1;
            first_size_reg <= '0;
            size_same_reg  <= 1'b1;
            first_key_reg  <= 1'b0;
            key_same_reg   <= 1'b1;
            offset_reg     <= 1'b0;
        end
        else if (head_pop)
        begin
            sum_reg        <= sum_next;
            count_reg      <= count_next;
            min_reg        <= min_next;
            sap_time_reg   <= sap_time_next;
            sap_seen_reg   <= sap_seen_next;
            first_dur_reg  <= first_dur_next;
            dur_same_reg   <= dur_same_next;
            first_size_reg <= first_size_next;
            size_same_reg  <= size_same_next;
            first_key_reg  <= first_key_next;
            key_same_reg   <= key_same_next;
            offset_reg     <= offset_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (closing)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (summaries.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (closing)
        begin
            out_reg <= summary;
        end
    end

    assign summaries.valid   = out_valid_reg;
    assign summaries.payload = out_reg;

endmodule

`default_nettype wire

>>> design/media_fragment_run_summarizer_top.sv
// Top level of the media fragment run summarizer.
// Joins the front (accept, classify, queue) and the back (statistics, output register).
// Depends on mfrs_pkg, mfrs_if, mfrs_front and mfrs_back.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one media sample per transfer on the samples channel and
// produces one fragment summary per transfer on the summaries channel, one
// for each sample that carries the end-of-fragment mark. Samples without
// that mark produce nothing visible; they only update the running statistics.
// Both channels transfer when valid and ready are high at a rising clock edge.
//
// Throughput is one sample per clock cycle, sustained while no closing sample waits for
// a free output register. The front compares the presentation and decode stamps and
// writes the sample into a queue of QUEUE_DEPTH entries; the back drains one entry per
// cycle under the same condition and updates the accumulators, which sets the rate.
// A closing sample is first written into the queue; the back then folds it in and
// registers its summary in the output register, which drives summaries.valid.
//
// When the receiver stalls, the finished summary waits in the output register.
// The back keeps folding in samples of the next fragment meanwhile and only
// holds when a second closing sample arrives while the first summary is still
// untaken; the queue then fills and samples.ready drops.
//
// Reset empties the queue and clears the output valid flag and all statistics; the base
// decode time starts at zero and the earliest presentation time at all ones.
module media_fragment_run_summarizer_top #(
    parameter int QUEUE_DEPTH = mfrs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire             clk,
    input  wire             rst_n,
    mfrs_sample_if.sink     samples,
    mfrs_summary_if.source  summaries
);
    import mfrs_pkg::*;

    logic        head_valid;
    mfrs_entry_t head_entry;
    logic        head_pop;

    mfrs_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .head_pop   (head_pop)
    );

    mfrs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .head_pop   (head_pop),
        .summaries  (summaries)
    );

endmodule

`default_nettype wire

>>> bench/media_fragment_run_summarizer_top_tb.sv
// Self-checking testbench for media_fragment_run_summarizer_top.
// Depends on mfrs_pkg, mfrs_if, mfrs_front, mfrs_back and the top from the design folder.
`timescale 1ns / 1ps

// The bench feeds media samples into the block and checks the fragment summaries that come
// back. An initial block builds the whole sample sequence up front and pushes it into
// stimulus_q. A clocked driver presents the queue head on the samples channel. On each
// transfer, the driver folds that sample into a private copy of the fragment statistics.
// When the sample closes a fragment, the predicted summary joins awaited_summaries. A clocked
// monitor drives summaries.ready and compares every summary transfer, field by field, with the
// oldest awaited summary.
//
// The run has three idling phases. First the sender idles 17 percent of the time and the
// receiver stalls 67 percent. Then the two rates swap. Then nobody idles. Some fragments are
// flagged so that the driver holds back their first sample until every awaited summary has
// arrived. This lets the block run dry now and then.
module media_fragment_run_summarizer_top_tb;
    import mfrs_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int RESET_CYCLES = 7;
    localparam int CYCLE_LIMIT = 40000;
    localparam int LINGER      = 20;

    // A queued sample with the idling phase it belongs to. A set drain_first makes the driver
    // wait for all awaited summaries before it offers the sample.
    typedef struct packed {
        mfrs_sample_t smp;
        logic [1:0]   phase;
        logic         drain_first;
    } stim_t;

    logic clk;
    logic rst_n = 1'b0;

    mfrs_sample_if  sample_bus ();
    mfrs_summary_if summary_bus ();

    media_fragment_run_summarizer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (sample_bus),
        .summaries (summary_bus)
    );

    stim_t         stimulus_q[$];
    mfrs_summary_t awaited_summaries[$];

    // The driver and the monitor each own one of these two counters. Their difference is the
    // number of summaries still in flight. Both update with nonblocking assignments, so each
    // side reads the other's count free of races.
    int summaries_predicted = 0;
    int summaries_checked   = 0;
    int mismatches          = 0;
    int cycle_count         = 0;

    logic [1:0] cur_phase = 2'd0;
    int send_idle_pct [3] = '{17, 67, 0};
    int recv_stall_pct[3] = '{67, 17, 0};

    // Private copy of the block's statistics.
    time_t  base_tm;
    time_t  frag_dur_sum;
    count_t frag_count;
    time_t  frag_min_pts;
    time_t  frag_sap_pts;
    logic   frag_sap_hit;
    dur_t   frag_dur0;
    logic   frag_dur_eq;
    size_t  frag_size0;
    logic   frag_size_eq;
    logic   frag_key0;
    logic   frag_key_eq;
    logic   frag_offs;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic void clear_fragment();
        frag_dur_sum = '0;
        frag_count   = '0;
        frag_min_pts = TIME_ALL_ONES;
        frag_sap_pts = '0;
        frag_sap_hit = 1'b0;
        frag_dur0    = '0;
        frag_dur_eq  = 1'b1;
        frag_size0   = '0;
        frag_size_eq = 1'b1;
        frag_key0    = 1'b0;
        frag_key_eq  = 1'b1;
        frag_offs    = 1'b0;
    endfunction

    // Folds one transferred sample into the fragment statistics. When the sample closes the
    // fragment, the function returns 1 with the summary the block should emit. Base time then
    // moves on by the fragment's duration.
    function automatic bit fold_into_fragment(input mfrs_sample_t s, output mfrs_summary_t sum);
        sum = '0;
        // The first sample of a fragment is the one that arrives while the count is zero.
        if (frag_count == '0)
        begin
            frag_dur0  = s.sample_duration;
            frag_size0 = s.sample_size;
            frag_key0  = s.key_frame;
        end
        else
        begin
            if (s.sample_duration != frag_dur0)
                frag_dur_eq = 1'b0;
            if (s.sample_size != frag_size0)
                frag_size_eq = 1'b0;
            if (s.key_frame != frag_key0)
                frag_key_eq = 1'b0;
        end
        if (frag_count != COUNT_MAX)
            frag_count = frag_count + 1'b1;
        frag_dur_sum = frag_dur_sum + time_t'(s.sample_duration);
        if (s.present_time < frag_min_pts)
            frag_min_pts = s.present_time;
        if (s.key_frame && !frag_sap_hit)
        begin
            frag_sap_hit = 1'b1;
            frag_sap_pts = s.present_time;
        end
        if (s.present_time != s.decode_stamp)
            frag_offs = 1'b1;
        if (!s.ends_fragment)
            return 1'b0;

        sum.count_of_samples = frag_count;
        sum.total_duration   = frag_dur_sum;
        sum.base_decode_time = base_tm;
        sum.earliest_present = frag_min_pts;
        sum.sap_found        = frag_sap_hit;
        sum.sap_delta        = frag_sap_hit ? time_t'(frag_sap_pts - frag_min_pts) : '0;
        sum.opens_on_key     = frag_key0;
        sum.common_duration  = frag_dur_eq ? frag_dur0 : '0;
        sum.sizes_uniform    = frag_size_eq;
        sum.common_size      = frag_size0;
        sum.flags_uniform    = frag_key_eq;
        sum.offsets_present  = frag_offs;
        base_tm = base_tm + frag_dur_sum;
        clear_fragment();
        return 1'b1;
    endfunction

    function automatic time_t rand_time();
        return time_t'({$urandom, $urandom});
    endfunction

    task automatic add_sample(input size_t sz, input dur_t du, input logic key,
                              input time_t pts, input time_t dts, input logic last,
                              input logic [1:0] ph, input logic drain);
        stim_t st;
        st.smp.sample_size     = sz;
        st.smp.sample_duration = du;
        st.smp.key_frame       = key;
        st.smp.present_time    = pts;
        st.smp.decode_stamp    = dts;
        st.smp.ends_fragment   = last;
        st.phase               = ph;
        st.drain_first         = drain;
        stimulus_q = {stimulus_q, st};
    endtask

    // A well-formed fragment with random content. Sizes and durations are often shared, so
    // the uniform flags come out both ways. The key pattern is one of four kinds, and the
    // timestamps mix no offset, positive offsets and presentation below decode time.
    task automatic add_random_fragment(input logic [1:0] ph, input logic drain);
        int    n;
        int    key_mode;
        int    off_mode;
        bit    sz_same;
        bit    du_same;
        size_t sz0;
        dur_t  du0;
        size_t sz;
        dur_t  du;
        logic  k;
        time_t dts;
        time_t pts;
        n        = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
        sz_same  = ($urandom_range(99) < 40);
        du_same  = ($urandom_range(99) < 50);
        key_mode = $urandom_range(3);
        sz0      = ($urandom_range(1) == 1) ? size_t'($urandom_range(100, 20000)) : $urandom;
        du0      = ($urandom_range(1) == 1) ? dur_t'($urandom_range(1, 4000)) : $urandom;
        if (du0 == '0)
            du0 = 1;
        dts = ($urandom_range(3) == 0) ? time_t'(TIME_ALL_ONES - $urandom_range(50000))
                                       : rand_time();
        for (int i = 0; i < n; i++)
        begin
            sz = sz_same ? sz0 : size_t'($urandom);
            du = du_same ? du0 : dur_t'($urandom_range(1, 8000));
            if (!du_same && $urandom_range(4) == 0)
                du = $urandom;
            if (du == '0)
                du = 1;
            case (key_mode)
                0: k = 1'b0;
                1: k = 1'b1;
                2: k = 1'($urandom_range(1));
                default: k = (i == 0);
            endcase
            off_mode = $urandom_range(3);
            if (off_mode <= 1)
                pts = dts;
            else if (off_mode == 2)
                pts = dts + time_t'($urandom_range(90000));
            else
                pts = dts - time_t'($urandom_range(1, 90000));
            add_sample(sz, du, k, pts, dts, i == n - 1, ph, drain && i == 0);
            dts = dts + time_t'(du);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] exp);
        if (got !== exp)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s: expected %h, got %h", name, exp, got);
        end
    endtask

    // Sample driver. A sample on the bus stays there until it is transferred. Otherwise, the
    // next queued sample is offered unless this cycle is an idle one or the sample waits for
    // the block to run dry.
    always @(posedge clk or negedge rst_n)
    begin : sample_driver
        mfrs_summary_t sum;
        int            outstanding;
        logic          go;
        if (!rst_n)
        begin
            sample_bus.valid   <= 1'b0;
            sample_bus.payload <= '0;
        end
        else
        begin
            outstanding = summaries_predicted - summaries_checked;
            if (sample_bus.valid && sample_bus.ready)
            begin
                if (fold_into_fragment(sample_bus.payload, sum))
                begin
                    awaited_summaries = {awaited_summaries, sum};
                    summaries_predicted <= summaries_predicted + 1;
                    outstanding++;
                end
                void'(stimulus_q.pop_front());
            end
            if (sample_bus.valid && !sample_bus.ready)
            begin
                // Held: the sample on the bus has not been transferred yet.
            end
            else if (stimulus_q.size() == 0)
                sample_bus.valid <= 1'b0;
            else
            begin
                go = 1'b1;
                if (stimulus_q[0].drain_first && outstanding != 0)
                    go = 1'b0;
                else if ($urandom_range(99) < send_idle_pct[stimulus_q[0].phase])
                    go = 1'b0;
                sample_bus.valid   <= go;
                sample_bus.payload <= stimulus_q[0].smp;
                cur_phase          <= stimulus_q[0].phase;
            end
        end
    end

    // Summary monitor. It checks each summary transfer against the oldest prediction, and it
    // stalls the summaries channel at the rate of the current phase.
    always @(posedge clk or negedge rst_n)
    begin : summary_monitor
        mfrs_summary_t want;
        mfrs_summary_t got;
        if (!rst_n)
            summary_bus.ready <= 1'b0;
        else
        begin
            if (summary_bus.valid && summary_bus.ready)
            begin
                got = summary_bus.payload;
                if (awaited_summaries.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("summary with none expected: %h", got);
                end
                else
                begin
                    want = awaited_summaries.pop_front();
                    summaries_checked <= summaries_checked + 1;
                    check_field("count_of_samples", 64'(got.count_of_samples),
                                64'(want.count_of_samples));
                    check_field("total_duration", 64'(got.total_duration),
                                64'(want.total_duration));
                    check_field("base_decode_time", 64'(got.base_decode_time),
                                64'(want.base_decode_time));
                    check_field("earliest_present", 64'(got.earliest_present),
                                64'(want.earliest_present));
                    check_field("sap_found", 64'(got.sap_found), 64'(want.sap_found));
                    check_field("sap_delta", 64'(got.sap_delta), 64'(want.sap_delta));
                    check_field("opens_on_key", 64'(got.opens_on_key),
                                64'(want.opens_on_key));
                    check_field("common_duration", 64'(got.common_duration),
                                64'(want.common_duration));
                    check_field("sizes_uniform", 64'(got.sizes_uniform),
                                64'(want.sizes_uniform));
                    check_field("common_size", 64'(got.common_size), 64'(want.common_size));
                    check_field("flags_uniform", 64'(got.flags_uniform),
                                64'(want.flags_uniform));
                    check_field("offsets_present", 64'(got.offsets_present),
                                64'(want.offsets_present));
                end
            end
            summary_bus.ready <= ($urandom_range(99) >= recv_stall_pct[cur_phase]);
        end
    end

    // Watchdog for a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus_and_end
        time_t pts;
        logic  ph_pick;
        sample_bus.valid   = 1'b0;
        sample_bus.payload = '0;
        summary_bus.ready  = 1'b0;
        base_tm = '0;
        clear_fragment();

        // Directed samples. A lone sample with zero size, zero duration and no key frame.
        add_sample('0, '0, 1'b0, '0, '0, 1'b1, 2'd0, 1'b0);
        // A lone sample with every field at its maximum.
        add_sample('1, '1, 1'b1, '1, '1, 1'b1, 2'd0, 1'b0);
        // Presentation below and above decode time. The key frame comes second, and the
        // earliest time comes last. Durations are equal but sizes are not.
        add_sample(32'd100, 32'd1000, 1'b0, 48'd5000, 48'd6000, 1'b0, 2'd0, 1'b0);
        add_sample(32'd200, 32'd1000, 1'b1, 48'd9000, 48'd7000, 1'b0, 2'd0, 1'b0);
        add_sample(32'd100, 32'd1000, 1'b0, 48'd2000, 48'd8000, 1'b1, 2'd0, 1'b0);
        // A fully uniform fragment of key frames with no composition offsets.
        for (int i = 0; i < 4; i++)
            add_sample(32'd1500, 32'd3003, 1'b1, 48'd90000 + 48'(3003 * i),
                       48'd90000 + 48'(3003 * i), i == 3, 2'd0, 1'b0);
        // A key frame at the top of the time range, then a key frame at zero. The SAP delta
        // spans the whole range, and the durations differ.
        add_sample(32'd7, '1, 1'b1, '1, '0, 1'b0, 2'd0, 1'b0);
        add_sample(32'd7, 32'd1, 1'b1, '0, '0, 1'b1, 2'd0, 1'b0);
        // Alternating bit patterns in every field.
        add_sample(32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555,
                   1'b0, 2'd0, 1'b0);
        add_sample(32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA,
                   1'b1, 2'd0, 1'b0);

        // Random part. Most entries are well-formed fragments. About one in eight is a lone
        // sample with random content and a random end-of-fragment mark. The first fragment of
        // each phase, and a few more, first wait for the block to run dry.
        for (int ph = 0; ph < 3; ph++)
        begin
            add_random_fragment(ph[1:0], 1'b1);
            while (stimulus_q.size() < 13 + 178 * (ph + 1))
            begin
                if ($urandom_range(7) == 0)
                begin
                    pts = rand_time();
                    ph_pick = 1'($urandom_range(1));
                    add_sample($urandom, dur_t'($urandom_range(1, 32'hFFFF_FFFF)),
                               1'($urandom_range(1)), pts, ph_pick ? pts : rand_time(),
                               1'($urandom_range(1)), ph[1:0], 1'b0);
                end
                else
                    add_random_fragment(ph[1:0], $urandom_range(14) == 0);
            end
        end
        // Close any fragment that a noise sample left open.
        add_sample($urandom, 32'd1, 1'b0, '0, '0, 1'b1, 2'd2, 1'b0);
        // A last fragment that starts only once the block has run dry.
        add_random_fragment(2'd2, 1'b1);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (stimulus_q.size() != 0 || sample_bus.valid ||
               summaries_predicted != summaries_checked);
        repeat (LINGER) @(posedge clk);

        if (mismatches == 0 && awaited_summaries.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
